/* rtl/satt_pkg.sv */
// Shared types and constants for the set-associative transposition table.
`default_nettype none
package satt_pkg;
  localparam logic [1:0] EXACT_BOUND = 2'd3;
  localparam logic [7:0] AGE_WRAP = 8'd3;
  localparam logic [7:0] AGE_BITS = 8'hFC;
  localparam logic OP_PROBE = 1'b0;
  localparam logic OP_STORE = 1'b1;

  typedef struct packed {
    logic capture;
    logic write_back;
    logic clear;
  } satt_cmd_t;

  typedef struct packed {
    logic clear_done;
  } satt_status_t;
endpackage
`default_nettype wire

/* rtl/satt_ram.sv */
// Generic single-port RAM with registered read.
`default_nettype none
module satt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

/* rtl/satt_ctrl.sv */
// Controller state machine for the transposition table.
`default_nettype none
module satt_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  input  wire satt_pkg::satt_status_t status,
  output satt_pkg::satt_cmd_t       cmd
);
  typedef enum logic [1:0] {CLEAR, IDLE, READ, HOLD} state_t;
  state_t state;

  assign in_stall = (state != IDLE) || (out_valid && out_stall);
  assign cmd.capture = (state == IDLE) && in_valid && !in_stall;
  assign cmd.write_back = (state == READ);
  assign cmd.clear = (state == CLEAR);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CLEAR;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        CLEAR: begin
          if (status.clear_done) begin
            state <= IDLE;
          end
        end
        IDLE: begin
          if (cmd.capture) begin
            state <= READ;
          end
        end
        READ: begin
          state <= IDLE;
          out_valid <= 1'b1;
        end
        HOLD: state <= IDLE;
        default: state <= IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

/* rtl/satt_dp.sv */
// Datapath: set memories, way selection and write-back.
`default_nettype none
module satt_dp #(
  parameter int SETS = 1024,
  parameter int WAYS = 3,
  parameter int TAG_BITS = 16,
  parameter int DEPTH_OFFSET = -7
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire satt_pkg::satt_cmd_t   cmd,
  output satt_pkg::satt_status_t     status,
  input  wire logic [7:0]            current_age,
  input  wire logic                  operation,
  input  wire logic [63:0]           key,
  input  wire logic [1:0]            way_select,
  input  wire logic signed [8:0]     search_depth,
  input  wire logic [1:0]            bound_kind,
  input  wire logic signed [15:0]    score,
  input  wire logic signed [15:0]    static_eval,
  input  wire logic [15:0]           best_move,
  output logic                       hit,
  output logic [1:0]                 way_chosen,
  output logic [7:0]                 entry_depth,
  output logic [7:0]                 entry_bound_age,
  output logic [15:0]                entry_move,
  output logic signed [15:0]         entry_score,
  output logic signed [15:0]         entry_eval,
  output logic                       written
);
  localparam int SET_BITS = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int EW = TAG_BITS + 8 + 8 + 16 + 16 + 16;
  localparam logic [7:0] DOFF = 8'(-DEPTH_OFFSET);

  typedef struct packed {
    logic [TAG_BITS-1:0] tag;
    logic [7:0] depth;
    logic [7:0] bound_age;
    logic [15:0] move;
    logic [15:0] score;
    logic [15:0] eval;
  } entry_t;

  logic op_q;
  logic [TAG_BITS-1:0] tag_q;
  logic [SET_BITS-1:0] set_q, clr_idx, addr;
  logic [1:0] way_q, bound_q;
  logic [7:0] dbyte_q;
  logic [15:0] score_q, eval_q, move_q;
  entry_t rd [WAYS];
  entry_t wr [WAYS];
  logic [WAYS-1:0] we;

  assign status.clear_done = (clr_idx == SET_BITS'(SETS - 1));
  assign addr = cmd.clear ? clr_idx : (cmd.capture ? SET_BITS'(key % SETS) : set_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (cmd.clear && !status.clear_done) begin
      clr_idx <= clr_idx + 1'b1;
    end
    if (cmd.capture) begin
      op_q <= operation;
      tag_q <= key[63 -: TAG_BITS];
      set_q <= SET_BITS'(key % SETS);
      way_q <= way_select;
      bound_q <= bound_kind;
      dbyte_q <= search_depth[7:0] + DOFF;
      score_q <= score;
      eval_q <= static_eval;
      move_q <= best_move;
    end
  end

  for (genvar g = 0; g < WAYS; g++) begin : g_way
    satt_ram #(.WIDTH(EW), .DEPTH(SETS)) u_ram (
      .clk(clk), .we(we[g]), .addr(addr), .wdata(wr[g]), .rdata(rd[g])
    );
  end

  logic found;
  logic [1:0] fw, vw, sel;
  logic signed [10:0] best, worth;
  entry_t ce;
  logic do_store;

  always_comb begin
    found = 1'b0;
    fw = '0;
    vw = '0;
    best = '0;
    worth = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (rd[w].tag == tag_q || rd[w].depth == 8'd0) begin
        found = 1'b1;
        fw = 2'(w);
      end
    end
    for (int w = 0; w < WAYS; w++) begin
      worth = $signed({3'b000, rd[w].depth})
        - $signed({2'b00, ((satt_pkg::AGE_WRAP + current_age - rd[w].bound_age)
        & satt_pkg::AGE_BITS), 1'b0});
      if (w == 0 || worth < best) begin
        best = worth;
        vw = 2'(w);
      end
    end
    sel = found ? fw : vw;
    ce = rd[0];
    for (int w = 0; w < WAYS; w++) begin
      if (sel == 2'(w)) ce = rd[w];
    end
    do_store = 1'b0;
    for (int w = 0; w < WAYS; w++) begin
      if (way_q == 2'(w)) begin
        do_store = bound_q == satt_pkg::EXACT_BOUND || rd[w].tag != tag_q
          || ({1'b0, dbyte_q} + 9'd3) >= {1'b0, rd[w].depth};
      end
    end
    for (int w = 0; w < WAYS; w++) begin
      we[w] = cmd.clear;
      wr[w] = '0;
      if (cmd.write_back) begin
        if (op_q == satt_pkg::OP_STORE) begin
          we[w] = do_store && way_q == 2'(w);
          wr[w] = '{tag_q, dbyte_q, {current_age[7:2], current_age[1:0] | bound_q},
                    move_q, score_q, eval_q};
        end else begin
          we[w] = found && fw == 2'(w);
          wr[w] = rd[w];
          wr[w].bound_age = (rd[w].bound_age & 8'h03) | current_age;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write_back) begin
      way_chosen <= (op_q == satt_pkg::OP_STORE) ? way_q : sel;
      if (op_q == satt_pkg::OP_STORE) begin
        hit <= 1'b0;
        written <= do_store && (32'(way_q) < WAYS);
        entry_depth <= '0;
        entry_bound_age <= '0;
        entry_move <= '0;
        entry_score <= '0;
        entry_eval <= '0;
      end else begin
        hit <= found && ce.depth != 8'd0;
        written <= 1'b0;
        entry_depth <= ce.depth;
        entry_bound_age <= found ? ((ce.bound_age & 8'h03) | current_age) : ce.bound_age;
        entry_move <= ce.move;
        entry_score <= ce.score;
        entry_eval <= ce.eval;
      end
    end
  end
endmodule
`default_nettype wire

/* rtl/set_assoc_transposition_table.sv */
// Top level of the set-associative transposition table.
// Each transaction is a registered read of all ways of a set, then the way decision and
// write-back of that set. A result that waits at the output holds off the next
// transaction until it is taken. After reset the block clears every set of the tables
// before it accepts the first transaction; age writes are taken at any time.
`default_nettype none
module set_assoc_transposition_table #(
  parameter int SETS = 1024,
  parameter int WAYS = 3,
  parameter int TAG_BITS = 16,
  parameter int DEPTH_OFFSET = -7
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [7:0]         cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               operation,
  input  wire logic [63:0]        key,
  input  wire logic [1:0]         way_select,
  input  wire logic signed [8:0]  search_depth,
  input  wire logic [1:0]         bound_kind,
  input  wire logic signed [15:0] score,
  input  wire logic signed [15:0] static_eval,
  input  wire logic [15:0]        best_move,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    hit,
  output logic [1:0]              way_chosen,
  output logic [7:0]              entry_depth,
  output logic [7:0]              entry_bound_age,
  output logic [15:0]             entry_move,
  output logic signed [15:0]      entry_score,
  output logic signed [15:0]      entry_eval,
  output logic                    written
);
  satt_pkg::satt_cmd_t cmd;
  satt_pkg::satt_status_t status;
  logic [7:0] current_age;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      current_age <= '0;
    end else if (cfg_valid) begin
      current_age <= cfg_data;
    end
  end

  satt_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .status(status), .cmd(cmd)
  );

  satt_dp #(.SETS(SETS), .WAYS(WAYS), .TAG_BITS(TAG_BITS), .DEPTH_OFFSET(DEPTH_OFFSET))
  u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status), .current_age(current_age),
    .operation(operation), .key(key), .way_select(way_select),
    .search_depth(search_depth), .bound_kind(bound_kind), .score(score),
    .static_eval(static_eval), .best_move(best_move), .hit(hit),
    .way_chosen(way_chosen), .entry_depth(entry_depth),
    .entry_bound_age(entry_bound_age), .entry_move(entry_move),
    .entry_score(entry_score), .entry_eval(entry_eval), .written(written)
  );
endmodule
`default_nettype wire

/* rtl/satt_checker.sv */
// Port-level assertions for the transposition table and their binding.
`default_nettype none
module satt_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic hit,
  input wire logic written
);
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall) else $error("second transaction taken early");
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> ##1 out_valid) else $error("result missing");
  a_hit_written: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(hit && written)) else $error("hit and written together");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid) else $error("stalled result dropped");
endmodule

bind set_assoc_transposition_table satt_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .hit(hit), .written(written)
);
`default_nettype wire

/* tb/sv/set_assoc_transposition_table_tb.sv */
// Self-checking testbench for the set-associative transposition table with a built-in predictor.
`default_nettype none
module set_assoc_transposition_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETS = 1024;
  localparam int WAYS = 3;
  localparam int TAG_BITS = 16;
  localparam int DEPTH_OFFSET = -7;
  localparam int ENTRIES = SETS * WAYS;

  typedef struct packed {
    logic        hit;
    logic [1:0]  way;
    logic [7:0]  depth;
    logic [7:0]  bound_age;
    logic [15:0] move;
    logic [15:0] score;
    logic [15:0] eval;
    logic        written;
  } lookup_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [7:0] cfg_data = 0;
  logic in_valid = 0;
  logic in_stall;
  logic operation = satt_pkg::OP_PROBE;
  logic [63:0] key = 0;
  logic [1:0] way_select = 0;
  logic signed [8:0] search_depth = 0;
  logic [1:0] bound_kind = 0;
  logic signed [15:0] score = 0;
  logic signed [15:0] static_eval = 0;
  logic [15:0] best_move = 0;
  logic out_valid;
  logic out_stall = 0;
  logic hit;
  logic [1:0] way_chosen;
  logic [7:0] entry_depth;
  logic [7:0] entry_bound_age;
  logic [15:0] entry_move;
  logic signed [15:0] entry_score;
  logic signed [15:0] entry_eval;
  logic written;

  set_assoc_transposition_table #(
    .SETS(SETS), .WAYS(WAYS), .TAG_BITS(TAG_BITS), .DEPTH_OFFSET(DEPTH_OFFSET)
  ) dut (.*);

  always #1 clk = ~clk;

  logic [7:0] age_reg;
  logic [15:0] tag_mem[ENTRIES];
  logic [7:0] depth_mem[ENTRIES];
  logic [7:0] ba_mem[ENTRIES];
  logic [15:0] move_mem[ENTRIES];
  logic [15:0] score_mem[ENTRIES];
  logic [15:0] eval_mem[ENTRIES];

  lookup_t pending_lookups[$];
  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  logic timed_out = 0;

  function automatic int replace_worth(int e);
    logic [7:0] age_gap;
    age_gap = (satt_pkg::AGE_WRAP + age_reg - ba_mem[e]) & satt_pkg::AGE_BITS;
    return int'(depth_mem[e]) - 2 * int'(age_gap);
  endfunction

  function automatic lookup_t table_access(logic op, logic [63:0] k, logic [1:0] ws,
                                           logic signed [8:0] sd, logic [1:0] bk,
                                           logic [15:0] sc, logic [15:0] ev,
                                           logic [15:0] mv);
    lookup_t r;
    logic [15:0] tag;
    int base, chosen, e, best, v;
    logic [7:0] dbyte;
    r = '0;
    tag = k[63 -: TAG_BITS];
    base = int'(k % SETS) * WAYS;
    if (op == satt_pkg::OP_PROBE) begin
      chosen = -1;
      for (int w = 0; w < WAYS; w++) begin
        if (chosen < 0 && (tag_mem[base+w] == tag || depth_mem[base+w] == 0)) chosen = w;
      end
      if (chosen >= 0) begin
        e = base + chosen;
        r.hit = depth_mem[e] != 0;
        ba_mem[e] = (ba_mem[e] & 8'h03) | age_reg;
      end else begin
        chosen = 0;
        best = replace_worth(base);
        for (int w = 1; w < WAYS; w++) begin
          v = replace_worth(base + w);
          if (v < best) begin
            best = v;
            chosen = w;
          end
        end
        e = base + chosen;
      end
      r.way = chosen[1:0];
      r.depth = depth_mem[e];
      r.bound_age = ba_mem[e];
      r.move = move_mem[e];
      r.score = score_mem[e];
      r.eval = eval_mem[e];
    end else begin
      r.way = ws;
      dbyte = 8'(int'(sd) - DEPTH_OFFSET);
      if (int'(ws) < WAYS) begin
        e = base + ws;
        if (bk == satt_pkg::EXACT_BOUND || tag_mem[e] != tag
            || int'(dbyte) + 3 >= int'(depth_mem[e]))
        begin
          tag_mem[e] = tag;
          depth_mem[e] = dbyte;
          ba_mem[e] = {6'd0, bk} | age_reg;
          move_mem[e] = mv;
          score_mem[e] = sc;
          eval_mem[e] = ev;
          r.written = 1'b1;
        end
      end
    end
    return r;
  endfunction

  task automatic send_item(logic op, logic [63:0] k, logic [1:0] ws = '0,
                           logic signed [8:0] sd = '0, logic [1:0] bk = '0,
                           logic [15:0] sc = '0, logic [15:0] ev = '0,
                           logic [15:0] mv = '0);
    @(posedge clk);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    in_valid <= 1;
    operation <= op;
    key <= k;
    way_select <= ws;
    search_depth <= sd;
    bound_kind <= bk;
    score <= sc;
    static_eval <= ev;
    best_move <= mv;
    do @(posedge clk); while (in_stall);
    pending_lookups.push_back(table_access(op, k, ws, sd, bk, sc, ev, mv));
    in_valid <= 0;
  endtask

  task automatic drain();
    while (pending_lookups.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_age(logic [7:0] a);
    drain();
    cfg_valid <= 1;
    cfg_data <= a;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    age_reg = a;
  endtask

  function automatic logic [63:0] make_key(int set, logic [15:0] tag);
    logic [63:0] k;
    k = {$urandom, $urandom};
    k[63 -: 16] = tag;
    k[9:0] = set[9:0];
    return k;
  endfunction

  always @(posedge clk) begin
    lookup_t got, want;
    if (!rst) out_stall <= ($urandom_range(99) < recv_idle_pct);
    if (!rst && out_valid && !out_stall) begin
      got = '{hit, way_chosen, entry_depth, entry_bound_age, entry_move, entry_score,
              entry_eval, written};
      if (pending_lookups.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected transaction: %h", got);
      end else begin
        want = pending_lookups.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("Mismatch: expected %h, actual %h", want, got);
        end
      end
    end
  end

  task automatic test_directed();
    logic [63:0] k;
    k = make_key(5, 16'hBEEF);
    send_item(satt_pkg::OP_PROBE, k);
    send_item(satt_pkg::OP_STORE, k, 2'd0, -9'sd7, 2'd1, 16'sh8000, 16'sh7FFF, 16'hFFFF);
    send_item(satt_pkg::OP_PROBE, k);
    send_item(satt_pkg::OP_STORE, k, 2'd0, 9'sd248, 2'd0, 16'sh7FFF, 16'sh8000, 16'h0000);
    send_item(satt_pkg::OP_STORE, k, 2'd0, 9'sd0, 2'd0, 16'd1, 16'd2, 16'd3);
    send_item(satt_pkg::OP_STORE, k, 2'd0, 9'sd0, satt_pkg::EXACT_BOUND, 16'd4, 16'd5, 16'd6);
    send_item(satt_pkg::OP_STORE, k, 2'd3, 9'sd10, 2'd2, 16'd7, 16'd8, 16'd9);
    for (int w = 0; w < WAYS; w++)
      send_item(satt_pkg::OP_STORE, make_key(5, 16'(32'h1000 + w)), w[1:0], 9'(20 + w),
                2'd2, 16'd1, 16'd1, 16'd1);
    send_item(satt_pkg::OP_PROBE, make_key(5, 16'h1001));
    send_item(satt_pkg::OP_PROBE, make_key(5, 16'h2222));
    send_item(satt_pkg::OP_PROBE, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(satt_pkg::OP_PROBE, 64'h0);
  endtask

  task automatic test_aging();
    write_age(8'd252);
    send_item(satt_pkg::OP_PROBE, make_key(5, 16'h1000));
    send_item(satt_pkg::OP_PROBE, make_key(5, 16'h3333));
    write_age(8'd7);
    send_item(satt_pkg::OP_PROBE, make_key(5, 16'h1002));
    send_item(satt_pkg::OP_PROBE, make_key(5, 16'h4444));
    write_age(8'd128);
    send_item(satt_pkg::OP_PROBE, make_key(5, 16'h5555));
  endtask

  task automatic random_phase(int n);
    logic [63:0] k;
    logic [15:0] tags[4];
    for (int i = 0; i < 4; i++) tags[i] = 16'($urandom);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) k = {$urandom, $urandom};
      else k = make_key($urandom_range(7), tags[$urandom_range(3)]);
      if ($urandom_range(1)) send_item(satt_pkg::OP_PROBE, k);
      else send_item(satt_pkg::OP_STORE, k, 2'($urandom),
                     9'(int'($urandom_range(255)) - 7), 2'($urandom),
                     16'($urandom), 16'($urandom), 16'($urandom));
      if (i == n / 2) drain();
    end
  endtask

  initial begin
    age_reg = 0;
    for (int e = 0; e < ENTRIES; e++) begin
      tag_mem[e] = 0; depth_mem[e] = 0; ba_mem[e] = 0;
      move_mem[e] = 0; score_mem[e] = 0; eval_mem[e] = 0;
    end
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    test_aging();
    send_idle_pct = 10; recv_idle_pct = 78;
    random_phase(260);
    write_age(8'd0);
    send_idle_pct = 78; recv_idle_pct = 10;
    random_phase(260);
    write_age(8'd64);
    send_idle_pct = 0; recv_idle_pct = 0;
    random_phase(260);
    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && !timed_out)
      $display("** set_assoc_transposition_table: PASSED **");
    else
      $display("** set_assoc_transposition_table: FAILED **");
    $finish;
  end

  initial begin
    #2000000;
    timed_out = 1;
    $display("** set_assoc_transposition_table: FAILED **");
    $finish;
  end
endmodule
`default_nettype wire
